>>> rtl/core/midi_rsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI running-status parser package
// Shared types, kind codes and helpers for the parser front, queue and back.
// ----------------------------------------------------------------------------
package midi_rsp_pkg;

    localparam int unsigned KindWidth  = 3;
    localparam int unsigned QueueDepth = 2;
    localparam int unsigned CountWidth = $clog2(QueueDepth + 1);
    localparam int unsigned PtrWidth   = $clog2(QueueDepth);

    localparam logic [KindWidth-1:0] KIND_DESYNC   = 3'd0;
    localparam logic [KindWidth-1:0] KIND_REALTIME = 3'd1;
    localparam logic [KindWidth-1:0] KIND_SYSCOM   = 3'd2;
    localparam logic [KindWidth-1:0] KIND_STATUS   = 3'd3;
    localparam logic [KindWidth-1:0] KIND_DATA     = 3'd4;

    localparam logic [7:0] REALTIME_BASE = 8'hF8;
    localparam logic [7:0] SYSCOM_BASE   = 8'hF0;
    localparam logic [3:0] PROG_CHANGE   = 4'hC;
    localparam logic [3:0] CHAN_PRESSURE = 4'hD;

    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic [KindWidth-1:0] kind;
        logic [7:0]           rx_byte;
    } item_t;

    // True when a channel status byte takes two data bytes.
    function automatic logic needs_two(input logic [7:0] status);
        needs_two = !((status[7:4] == PROG_CHANGE) || (status[7:4] == CHAN_PRESSURE));
    endfunction

endpackage

>>> rtl/core/midi_rsp_front.sv
// ----------------------------------------------------------------------------
// MIDI parser front end
// Accepts input words and sorts each into desync, real-time, system, status
// or data before it enters the queue.
// ----------------------------------------------------------------------------
module midi_rsp_front
    import midi_rsp_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // rx_byte
    input  logic       s_tuser,   // req_type
    input  logic       q_ready,
    output logic       q_push,
    output item_t      q_item
);

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb begin
        q_item.rx_byte = s_tdata;
        priority if (s_tuser) begin
            q_item.kind = KIND_DESYNC;
        end else if (s_tdata >= REALTIME_BASE) begin
            q_item.kind = KIND_REALTIME;
        end else if (s_tdata >= SYSCOM_BASE) begin
            q_item.kind = KIND_SYSCOM;
        end else if (s_tdata[7]) begin
            q_item.kind = KIND_STATUS;
        end else begin
            q_item.kind = KIND_DATA;
        end
    end

endmodule

>>> rtl/core/midi_rsp_queue.sv
// ----------------------------------------------------------------------------
// MIDI parser queue
// A short first-in first-out store that decouples the front from the back.
// ----------------------------------------------------------------------------
module midi_rsp_queue
    import midi_rsp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  ready,
    input  logic  pop,
    output logic  valid,
    output item_t head
);

    item_t                 mem [QueueDepth];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountWidth-1:0] count_reg, count_next;

    assign ready = (count_reg != CountWidth'(QueueDepth));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountWidth'(QueueDepth))
        else $error("Queue count exceeds its depth.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !valid))
        else $error("Queue popped while empty.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Queue pointers disagree while empty.");

endmodule

>>> rtl/core/midi_rsp_back.sv
// ----------------------------------------------------------------------------
// MIDI parser back end
// Applies the running-status rules to each queued word and holds completed
// messages in an output register until they are taken.
// ----------------------------------------------------------------------------
module midi_rsp_back
    import midi_rsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  item_t       q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // msg_status, msg_data1, msg_data2, msg_length
);

    logic [7:0] running_reg, running_next;
    logic [7:0] current_reg, current_next;
    logic       need_two_reg, need_two_next;
    logic       have_first_reg, have_first_next;
    logic [6:0] first_data_reg, first_data_next;
    logic       desync_reg, desync_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_status_reg, out_status_next;
    logic [6:0] out_data1_reg, out_data1_next;
    logic [6:0] out_data2_reg, out_data2_next;
    logic [1:0] out_len_reg, out_len_next;

    logic [7:0] cur_eff;
    logic       need_two_eff;
    logic       have_first_eff;
    logic       produces;
    logic       out_free;

    assign cur_eff        = (current_reg != '0) ? current_reg : running_reg;
    assign need_two_eff   = (current_reg != '0) ? need_two_reg : needs_two(running_reg);
    assign have_first_eff = (current_reg != '0) ? have_first_reg : 1'b0;

    assign produces = (q_head.kind == KIND_REALTIME)
                   || ((q_head.kind == KIND_DATA) && !desync_reg && (cur_eff != '0)
                       && (!need_two_eff || have_first_eff));
    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = q_valid && (!produces || out_free);

    always_comb begin
        running_next    = running_reg;
        current_next    = current_reg;
        need_two_next   = need_two_reg;
        have_first_next = have_first_reg;
        first_data_next = first_data_reg;
        desync_next     = desync_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data1_next  = out_data1_reg;
        out_data2_next  = out_data2_reg;
        out_len_next    = out_len_reg;

        if (q_pop) begin
            unique case (q_head.kind)
                KIND_DESYNC: begin
                    running_next    = '0;
                    current_next    = '0;
                    need_two_next   = 1'b0;
                    have_first_next = 1'b0;
                    first_data_next = '0;
                    desync_next     = 1'b1;
                end
                KIND_REALTIME: begin
                    out_valid_next  = 1'b1;
                    out_status_next = q_head.rx_byte;
                    out_data1_next  = '0;
                    out_data2_next  = '0;
                    out_len_next    = LEN_ONE;
                end
                KIND_SYSCOM: begin
                    running_next    = '0;
                    current_next    = '0;
                    need_two_next   = 1'b0;
                    have_first_next = 1'b0;
                    desync_next     = 1'b0;
                end
                KIND_STATUS: begin
                    running_next    = q_head.rx_byte;
                    current_next    = q_head.rx_byte;
                    need_two_next   = needs_two(q_head.rx_byte);
                    have_first_next = 1'b0;
                    desync_next     = 1'b0;
                end
                KIND_DATA: begin
                    if (!desync_reg && (cur_eff != '0)) begin
                        need_two_next = need_two_eff;
                        if (!need_two_eff) begin
                            out_valid_next  = 1'b1;
                            out_status_next = cur_eff;
                            out_data1_next  = q_head.rx_byte[6:0];
                            out_data2_next  = '0;
                            out_len_next    = LEN_TWO;
                            current_next    = '0;
                            have_first_next = 1'b0;
                        end else if (!have_first_eff) begin
                            first_data_next = q_head.rx_byte[6:0];
                            have_first_next = 1'b1;
                            current_next    = cur_eff;
                        end else begin
                            out_valid_next  = 1'b1;
                            out_status_next = cur_eff;
                            out_data1_next  = first_data_reg;
                            out_data2_next  = q_head.rx_byte[6:0];
                            out_len_next    = LEN_THREE;
                            current_next    = '0;
                            have_first_next = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg    <= '0;
            current_reg    <= '0;
            need_two_reg   <= 1'b0;
            have_first_reg <= 1'b0;
            first_data_reg <= '0;
            desync_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            running_reg    <= running_next;
            current_reg    <= current_next;
            need_two_reg   <= need_two_next;
            have_first_reg <= have_first_next;
            first_data_reg <= first_data_next;
            desync_reg     <= desync_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_data1_reg  <= out_data1_next;
        out_data2_reg  <= out_data2_next;
        out_len_reg    <= out_len_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_data2_reg, out_data1_reg, out_status_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        have_first_reg |-> ((current_reg != '0) && need_two_reg))
        else $error("First data byte held without a two-byte message open.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        desync_reg |-> ((running_reg == '0) && (current_reg == '0) && !have_first_reg))
        else $error("Parser state not cleared while out of sync.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_status_reg[7] && (out_len_reg != '0)
                           && ((out_len_reg == LEN_THREE) || (out_data2_reg == '0))))
        else $error("Malformed message in the output register.");

endmodule

>>> rtl/core/midi_running_status_parser.sv
// ----------------------------------------------------------------------------
// MIDI running-status parser
// Top level: front end, word queue and back end in a row.
// ----------------------------------------------------------------------------
// Each input word is one received MIDI byte (s_tuser low) or a forced loss of
// sync (s_tuser high). Completed channel messages and real-time bytes come out
// as one word carrying the status, up to two data bytes and the length. The
// parser takes one word per clock cycle while the queue has room: the back end
// applies the running status rules to the queued head word as it pops it, and a
// two-entry queue together with the output register keeps input flowing until
// the queue fills while a result waits. A result passes through the queue and
// then the output register before it is offered, and is held until taken.
module midi_running_status_parser
    import midi_rsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // msg_status, msg_data1, msg_data2, msg_length
);

    logic  q_ready;
    logic  q_push;
    item_t q_item;
    logic  q_pop;
    logic  q_valid;
    item_t q_head;

    midi_rsp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    midi_rsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    midi_rsp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
